@@ design/assert_macros.svh @@
// Assertion helpers for the rate table design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define CHECK_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("check failed");

// Check that an antecedent implies a consequent in the next cycle
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

@@ design/kswrt_pkg.sv @@
package kswrt_pkg;
   localparam int unsigned KEY_W = 64;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned CNT_W = 32;
   localparam int unsigned DEF_ENTRIES = 64;
   localparam int unsigned DEF_EVICT_BATCH = 32;
   localparam int unsigned DEF_SLOTS_LOG2 = 3;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Saturating add of two counter values
   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction
endpackage

@@ design/keyed_sliding_window_rate_table.sv @@
// The result follows the input transfer through the lookup, evict, update,
// bump and sum steps. The sequencer works on one item at a time and the
// input side reopens in the cycle after the result transfer.
// Disabled filter: result 0 is valid in the cycle after the transfer.
// Reset: synchronous, active high; clears table valid bits, ranks, slots.
module keyed_sliding_window_rate_table import kswrt_pkg::*; #(
   parameter int unsigned ENTRIES = DEF_ENTRIES,
   parameter int unsigned EVICT_BATCH = DEF_EVICT_BATCH,
   parameter int unsigned SLOTS_LOG2 = DEF_SLOTS_LOG2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [63:0] key, [95:64] time_eighths
   input  logic [95:0]  req_tdata,
   // [0] opcode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] rate
   output logic [31:0]  rsp_tdata
);
   `include "assert_macros.svh"
   localparam int unsigned RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned THR = (ENTRIES > EVICT_BATCH) ? ENTRIES - EVICT_BATCH : 0;

   typedef enum logic [2:0] {IDLE, LOOK, EVICT, UPD, BUMP, SUM, DONE} state_type;
   state_type state_ff;

   logic              en_ff;
   logic [KEY_W-1:0]  key_ff;
   logic              op_ff;
   logic [TIME_W-1:0] now_ff;
   logic              hit_ff;
   logic [RW-1:0]     pick_ff, hrank_ff;
   logic [CNT_W-1:0]  rate_ff;

   logic [ENTRIES-1:0] valid, match;
   logic [RW-1:0]      rank [ENTRIES];
   logic [CNT_W-1:0]   csum [ENTRIES];
   logic [CNT_W-1:0]   rsum [ENTRIES];
   logic               hit;
   logic [RW-1:0]      hidx, fidx;

   // Find first match and lowest free entry
   always_comb begin
      hit = 1'b0;
      hidx = '0;
      fidx = '0;
      for (int i = ENTRIES-1; i >= 0; i--) begin
         if (match[i]) begin
            hit = 1'b1;
            hidx = RW'(i);
         end
         if (!valid[i]) fidx = RW'(i);
      end
   end

   // On a miss the lowest free entry after eviction is allocated during UPD
   for (genvar e = 0; e < ENTRIES; e++) begin : g_ent
      kswrt_entry_cell #(.ENTRIES(ENTRIES), .SLOTS_LOG2(SLOTS_LOG2)) u_ent (
         .clock, .reset, .key(key_ff), .evict(&valid), .thr(RW'(THR)),
         .do_evict(state_ff == EVICT && !hit_ff),
         .alloc_sel(!hit_ff && fidx == RW'(e)), .age_all(!hit_ff),
         .hit_sel(hit_ff && pick_ff == RW'(e)), .hit_rank(hrank_ff),
         .touch(state_ff == UPD), .bump(state_ff == BUMP && pick_ff == RW'(e)),
         .op(op_ff), .now(now_ff), .valid(valid[e]), .match(match[e]),
         .rank(rank[e]), .conn_sum(csum[e]), .rec_sum(rsum[e]));
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = (state_ff == DONE);
   assign rsp_tdata = rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         en_ff <= 1'b0;
      end else begin
         if (csr_wr_en) en_ff <= csr_wr_data;
         case (state_ff)
            IDLE: if (req_tvalid) begin
               key_ff <= req_tdata[63:0];
               now_ff <= req_tdata[95:64];
               op_ff <= req_tuser;
               rate_ff <= '0;
               state_ff <= en_ff ? LOOK : DONE;
            end
            LOOK: begin
               hit_ff <= hit;
               pick_ff <= hidx;
               hrank_ff <= rank[hidx];
               state_ff <= EVICT;
            end
            EVICT: state_ff <= UPD;
            UPD: begin
               if (!hit_ff) pick_ff <= fidx;
               state_ff <= BUMP;
            end
            BUMP: state_ff <= SUM;
            SUM: begin
               rate_ff <= op_ff ? rsum[pick_ff] : csum[pick_ff];
               state_ff <= DONE;
            end
            DONE: if (rsp_tready) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   `CHECK_ALWAYS(a_one_side, clock, reset, !(req_tready && rsp_tvalid))
   `CHECK_NEXT(a_alloc_valid, clock, reset, state_ff == UPD, valid[pick_ff] || !hit_ff)
   `CHECK_NEXT(a_done_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule

@@ design/kswrt_slot_cell.sv @@
// One time slot of one kind: holds count and stamp, adds its share to the
// running sum that travels along the chain.
module kswrt_slot_cell import kswrt_pkg::*; #(
   parameter int unsigned SLOTS_LOG2 = DEF_SLOTS_LOG2,
   parameter logic [SLOTS_LOG2-1:0] SLOT_IDX = '0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              bump,
   input  logic [TIME_W-1:0] now,
   input  logic [CNT_W-1:0]  sum_in,
   output logic [CNT_W-1:0]  sum_out
);
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] stamp_ff, stamp_in;
   logic              mine;
   logic [TIME_W:0]   edge_lim;
   logic [CNT_W-1:0]  cnt_now;

   assign mine = (now[SLOTS_LOG2-1:0] == SLOT_IDX);

   // Reset a stale slot, then count
   always_comb begin
      count_in = count_ff;
      stamp_in = stamp_ff;
      cnt_now = '0;
      if (clear) begin
         count_in = '0;
         stamp_in = '0;
      end else if (bump && mine) begin
         stamp_in = now;
         cnt_now = (stamp_ff == now) ? count_ff : '0;
         count_in = (cnt_now == CNT_MAX) ? cnt_now : cnt_now + 1'b1;
      end
   end

   // Window test and chained sum
   assign edge_lim = {1'b0, stamp_ff} + (TIME_W+1)'(1 << SLOTS_LOG2);
   assign sum_out = (edge_lim >= {1'b0, now}) ? sat_add(sum_in, count_ff) : sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         stamp_ff <= '0;
      end else begin
         count_ff <= count_in;
         stamp_ff <= stamp_in;
      end
   end
endmodule

@@ design/kswrt_entry_cell.sv @@
// One table entry: key, valid, LRU rank and two rows of slot cells.
module kswrt_entry_cell import kswrt_pkg::*; #(
   parameter int unsigned ENTRIES = DEF_ENTRIES,
   parameter int unsigned SLOTS_LOG2 = DEF_SLOTS_LOG2,
   localparam int unsigned RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [KEY_W-1:0]  key,
   input  logic              evict,
   input  logic [RW-1:0]     thr,
   input  logic              do_evict,
   input  logic              alloc_sel,
   input  logic              age_all,
   input  logic              hit_sel,
   input  logic [RW-1:0]     hit_rank,
   input  logic              touch,
   input  logic              bump,
   input  logic              op,
   input  logic [TIME_W-1:0] now,
   output logic              valid,
   output logic              match,
   output logic [RW-1:0]     rank,
   output logic [CNT_W-1:0]  conn_sum,
   output logic [CNT_W-1:0]  rec_sum
);
   localparam int unsigned SLOTS = 1 << SLOTS_LOG2;
   logic [KEY_W-1:0] key_ff;
   logic             valid_ff, valid_in;
   logic [RW-1:0]    rank_ff, rank_in;
   logic [CNT_W-1:0] csum [SLOTS+1];
   logic [CNT_W-1:0] rsum [SLOTS+1];

   assign valid = valid_ff;
   assign rank = rank_ff;
   assign match = valid_ff && (key_ff == key);

   // Update valid and rank for eviction, allocation and hits
   always_comb begin
      valid_in = valid_ff;
      rank_in = rank_ff;
      if (do_evict && evict && valid_ff && rank_ff >= thr) valid_in = 1'b0;
      if (touch) begin
         if (alloc_sel) begin
            valid_in = 1'b1;
            rank_in = '0;
         end else if (hit_sel) begin
            rank_in = '0;
         end else if (valid_ff && (age_all || rank_ff < hit_rank)) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff <= rank_in;
      end
      if (touch && alloc_sel) key_ff <= key;
   end

   assign csum[0] = '0;
   assign rsum[0] = '0;
   for (genvar s = 0; s < SLOTS; s++) begin : g_slot
      kswrt_slot_cell #(.SLOTS_LOG2(SLOTS_LOG2),
                        .SLOT_IDX(SLOTS_LOG2'(s))) u_conn (
         .clock, .reset, .clear(touch && alloc_sel),
         .bump(bump && !op), .now, .sum_in(csum[s]), .sum_out(csum[s+1]));
      kswrt_slot_cell #(.SLOTS_LOG2(SLOTS_LOG2),
                        .SLOT_IDX(SLOTS_LOG2'(s))) u_rec (
         .clock, .reset, .clear(touch && alloc_sel),
         .bump(bump && op), .now, .sum_in(rsum[s]), .sum_out(rsum[s+1]));
   end
   assign conn_sum = csum[SLOTS];
   assign rec_sum = rsum[SLOTS];
endmodule
